// ----- rtl/pls_pkg.sv -----
// ----------------------------------------------------------------------------
// pls_pkg
// shared constants, request/response types and cell control for the
// positional list store
// ----------------------------------------------------------------------------
package pls_pkg;

    localparam int CAPACITY   = 128;
    localparam int DATA_WIDTH = 32;
    localparam int VALUE_W    = 32;
    localparam int POS_W      = 8;
    localparam int CNT_W      = 8;

    // two-level priority encode for find
    localparam int GROUP_SIZE = 16;
    localparam int NUM_GROUPS = CAPACITY / GROUP_SIZE;
    localparam int LOC_W      = $clog2(GROUP_SIZE);
    localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_FIND   = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // per-cell update codes
    localparam logic [1:0] CELL_HOLD  = 2'd0;
    localparam logic [1:0] CELL_LEFT  = 2'd1;
    localparam logic [1:0] CELL_RIGHT = 2'd2;
    localparam logic [1:0] CELL_LOAD  = 2'd3;

    typedef logic [DATA_WIDTH-1:0] t_word;

    typedef struct packed {
        logic [1:0]                command;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [POS_W-1:0] found_position;
        logic [CNT_W-1:0] count;
    } t_resp;

    typedef struct packed {
        logic [1:0] op;
        logic       valid;
        logic       cmp;
    } t_cell_ctrl;

    // sign-extend the request value and keep the low DATA_WIDTH bits
    function automatic t_word to_word(input logic [VALUE_W-1:0] v);
        logic [2*VALUE_W-1:0] ext;
        ext = {{VALUE_W{v[VALUE_W-1]}}, v};
        return ext[DATA_WIDTH-1:0];
    endfunction

endpackage

// ----- rtl/pls_cell.sv -----
// ----------------------------------------------------------------------------
// pls_cell
// one list slot: holds a word, shifts with its neighbors, flags a match
// ----------------------------------------------------------------------------
module pls_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pls_pkg::t_cell_ctrl i_ctrl,
    input  pls_pkg::t_word      i_left,
    input  pls_pkg::t_word      i_right,
    input  pls_pkg::t_word      i_key,
    output pls_pkg::t_word      o_word,
    output logic                o_match
);
    import pls_pkg::*;

    t_word r_word;
    logic  r_match;

    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            CELL_LEFT:  r_word <= i_left;
            CELL_RIGHT: r_word <= i_right;
            CELL_LOAD:  r_word <= i_key;
            default:    r_word <= r_word;
        endcase
    end

    // match flag held until the next find
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctrl.cmp) begin
            r_match <= i_ctrl.valid && (r_word == i_key);
        end
    end

    assign o_word  = r_word;
    assign o_match = r_match;

endmodule

// ----- rtl/pls_group_enc.sv -----
// ----------------------------------------------------------------------------
// pls_group_enc
// registered lowest-set-bit encoder over one group of match flags
// ----------------------------------------------------------------------------
module pls_group_enc (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic [pls_pkg::GROUP_SIZE-1:0]           i_flags,
    output logic                                     o_hit,
    output logic [pls_pkg::LOC_W-1:0]                o_idx
);
    import pls_pkg::*;

    logic             n_hit;
    logic [LOC_W-1:0] n_idx;
    logic             r_hit;
    logic [LOC_W-1:0] r_idx;

    always_comb begin
        n_hit = 1'b0;
        n_idx = '0;
        for (int k = GROUP_SIZE - 1; k >= 0; k--) begin
            if (i_flags[k]) begin
                n_hit = 1'b1;
                n_idx = LOC_W'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
    end

    assign o_hit = r_hit;
    assign o_idx = r_idx;

endmodule

// ----- rtl/positional_list_store.sv -----
// ----------------------------------------------------------------------------
// positional_list_store
// ordered list of signed words with 1-based positions, built as a chain of
// slot cells that shift together on insert and delete
// ----------------------------------------------------------------------------
// usage
//   a request (command, position, value) is taken on a rising edge with start
//   high and busy low. every request gives exactly one response (status,
//   found position, count), shown on o_resp for a single cycle with o_done
//   high; the receiver cannot stall, so it must take it in that cycle.
// request handling
//   insert and delete: cells from the position on shift or load in the
//   accept cycle; clear only zeroes the count. the response is registered,
//   shown in the next cycle, and busy stays low, so one such request per
//   cycle is sustained while no find is pending. find: goes through the
//   registered match flag in every cell, a registered 16-way group encode
//   and the pick across groups, with busy high in S_FIND_GRP and S_FIND_SEL.
// reset
//   synchronous, active low: count goes to zero, busy and o_done low. slot
//   contents are not cleared; only slots below the count are ever looked at.
// ----------------------------------------------------------------------------
module positional_list_store (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  pls_pkg::t_req  i_req,
    output logic           o_done,
    output pls_pkg::t_resp o_resp
);
    import pls_pkg::*;

    // find sequencer codes
    localparam logic [1:0] S_IDLE     = 2'd0;
    localparam logic [1:0] S_FIND_GRP = 2'd1;
    localparam logic [1:0] S_FIND_SEL = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_done,  n_done;
    t_resp            r_resp,  n_resp;

    // request decode
    logic             accept;
    logic [POS_W:0]   pos_ext;
    logic [POS_W:0]   cnt_ext;
    logic [POS_W-1:0] pos0;
    logic             ins_range_ok;
    logic             del_range_ok;
    logic             is_full;
    logic             do_insert;
    logic             do_delete;
    logic             do_find;
    t_word            key;

    // cell chain
    t_word                 cell_word  [CAPACITY];
    logic [CAPACITY-1:0]   cell_match;
    t_cell_ctrl            cell_ctrl  [CAPACITY];

    // group encode results
    logic [NUM_GROUPS-1:0] grp_hit;
    logic [LOC_W-1:0]      grp_idx [NUM_GROUPS];

    // final pick across groups
    logic                  sel_hit;
    logic [GRP_W-1:0]      sel_grp;
    logic [LOC_W-1:0]      sel_idx;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign key     = to_word(i_req.value);
    assign pos_ext = {1'b0, i_req.position};
    assign cnt_ext = (POS_W + 1)'(r_count);
    assign pos0    = i_req.position - POS_W'(1);

    // insert range check comes before the full check
    assign ins_range_ok = (i_req.position != '0) && (pos_ext <= cnt_ext + (POS_W + 1)'(1));
    assign del_range_ok = (i_req.position != '0) && (pos_ext <= cnt_ext);
    assign is_full      = (r_count == CNT_W'(CAPACITY));

    assign do_insert = accept && (i_req.command == CMD_INSERT) && ins_range_ok && !is_full;
    assign do_delete = accept && (i_req.command == CMD_DELETE) && del_range_ok;
    assign do_find   = accept && (i_req.command == CMD_FIND);

    // slot chain: slot k takes from k-1 on insert, from k+1 on delete
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam logic [POS_W-1:0] CELL_POS = POS_W'(g);
        localparam logic [CNT_W-1:0] CELL_CNT = CNT_W'(g);

        t_word left_word;
        t_word right_word;

        if (g == 0) begin : g_first
            assign left_word = '0;
        end else begin : g_mid_l
            assign left_word = cell_word[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_word = '0;
        end else begin : g_mid_r
            assign right_word = cell_word[g+1];
        end

        always_comb begin
            cell_ctrl[g].op = CELL_HOLD;
            if (do_insert && (CELL_POS == pos0)) begin
                cell_ctrl[g].op = CELL_LOAD;
            end else if (do_insert && (CELL_POS > pos0)) begin
                cell_ctrl[g].op = CELL_LEFT;
            end else if (do_delete && (CELL_POS >= pos0)) begin
                cell_ctrl[g].op = CELL_RIGHT;
            end
            cell_ctrl[g].valid = (CELL_CNT < r_count);
            cell_ctrl[g].cmp   = do_find;
        end

        pls_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (cell_ctrl[g]),
            .i_left  (left_word),
            .i_right (right_word),
            .i_key   (key),
            .o_word  (cell_word[g]),
            .o_match (cell_match[g])
        );
    end

    // first encode level, one per group of slots
    for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
        pls_group_enc u_enc (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_flags (cell_match[g*GROUP_SIZE +: GROUP_SIZE]),
            .o_hit   (grp_hit[g]),
            .o_idx   (grp_idx[g])
        );
    end

    // second level: lowest group with a hit
    always_comb begin
        sel_hit = 1'b0;
        sel_grp = '0;
        sel_idx = '0;
        for (int k = NUM_GROUPS - 1; k >= 0; k--) begin
            if (grp_hit[k]) begin
                sel_hit = 1'b1;
                sel_grp = GRP_W'(k);
                sel_idx = grp_idx[k];
            end
        end
    end

    // sequencer and response
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_done  = 1'b0;
        n_resp  = r_resp;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_resp.status         = ST_OK;
                    n_resp.found_position = '0;
                    case (i_req.command)
                        CMD_INSERT: begin
                            if (!ins_range_ok) begin
                                n_resp.status = ST_RANGE;
                            end else if (is_full) begin
                                n_resp.status = ST_FULL;
                            end else begin
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        CMD_DELETE: begin
                            if (!del_range_ok) begin
                                n_resp.status = ST_RANGE;
                            end else begin
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            // find goes through the encode stages
                        end
                    endcase
                    n_resp.count = n_count;
                    if (i_req.command == CMD_FIND) begin
                        n_state = S_FIND_GRP;
                    end else begin
                        n_done = 1'b1;
                    end
                end
            end
            S_FIND_GRP: begin
                n_state = S_FIND_SEL;
            end
            S_FIND_SEL: begin
                n_state              = S_IDLE;
                n_done               = 1'b1;
                n_resp.status        = ST_OK;
                n_resp.count         = r_count;
                n_resp.found_position = sel_hit
                    ? POS_W'({sel_grp, sel_idx}) + POS_W'(1)
                    : '0;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_resp <= n_resp;
    end

    assign o_done = r_done;
    assign o_resp = r_resp;

endmodule
